### rtl/core/rcbc_pkg.sv
// Shared types and constants for the region class byte counter.
package rcbc_pkg;

  localparam int MAX_BLOCKS_DEF  = 65536;
  localparam int BLOCK_SHIFT_DEF = 21;

  localparam logic [7:0] EVICTION_KIND = 8'd14;

  // Stream widths.
  localparam int IN_TDATA_W  = 160;
  localparam int OUT_TDATA_W = 384;

  // Input word layout in s_tdata.
  localparam int IDX_LSB  = 0;
  localparam int CLS_LSB  = 16;
  localparam int TYPE_LSB = 18;
  localparam int ADDR_LSB = 26;
  localparam int SIZE_LSB = 90;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic {
    REG_REGION_BASE = 1'b0,
    REG_BLOCK_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_EVICT  = 2'd1,
    CMD_IGNORE = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_IGNORED  = 2'd1,
    STATUS_REJECTED = 2'd2
  } status_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] entry_index;
    logic [1:0]  entry_class;
    logic [63:0] event_address;
    logic [63:0] event_size;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_OFF,
    S_LOOK,
    S_SEG,
    S_ACC,
    S_EMIT
  } back_state_t;

endpackage

### rtl/core/rcbc_front.sv
// Front end: accepts input words and classifies them into commands.
module rcbc_front (
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rcbc_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                              s_tuser,
  input  logic                              q_full,
  input  logic                              clearing,
  output logic                              push,
  output rcbc_pkg::cmd_t                    cmd
);

  logic [7:0] ev_kind;

  assign ev_kind  = s_tdata[rcbc_pkg::TYPE_LSB +: 8];
  assign s_tready = !q_full && !clearing;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    cmd.entry_index   = s_tdata[rcbc_pkg::IDX_LSB +: 16];
    cmd.entry_class   = s_tdata[rcbc_pkg::CLS_LSB +: 2];
    cmd.event_address = s_tdata[rcbc_pkg::ADDR_LSB +: 64];
    cmd.event_size    = s_tdata[rcbc_pkg::SIZE_LSB +: 64];
    if (!s_tuser) begin
      cmd.kind = rcbc_pkg::CMD_LOAD;
    end else if (ev_kind == rcbc_pkg::EVICTION_KIND) begin
      cmd.kind = rcbc_pkg::CMD_EVICT;
    end else begin
      cmd.kind = rcbc_pkg::CMD_IGNORE;
    end
  end

endmodule

### rtl/core/rcbc_queue.sv
// Short command queue between the front and back ends.
module rcbc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rcbc_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output rcbc_pkg::cmd_t  pop_cmd
);

  rcbc_pkg::cmd_t                   entries [rcbc_pkg::QUEUE_DEPTH];
  logic [rcbc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [rcbc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [rcbc_pkg::QCNT_W-1:0]      count;

  localparam logic [rcbc_pkg::QPTR_W-1:0] LAST_PTR =
    rcbc_pkg::QPTR_W'(rcbc_pkg::QUEUE_DEPTH - 1);

  assign full    = count == rcbc_pkg::QCNT_W'(rcbc_pkg::QUEUE_DEPTH);
  assign valid   = count != '0;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + rcbc_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + rcbc_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + rcbc_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - rcbc_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/rcbc_back.sv
// Back end: class store, range splitting sequencer, counters and output register.
module rcbc_back #(
  parameter int MAX_BLOCKS  = rcbc_pkg::MAX_BLOCKS_DEF,
  parameter int BLOCK_SHIFT = rcbc_pkg::BLOCK_SHIFT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [63:0]                       region_base,
  input  logic [16:0]                       block_count,
  input  logic                              q_valid,
  input  rcbc_pkg::cmd_t                    q_cmd,
  output logic                              q_pop,
  output logic                              clearing,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [rcbc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [1:0]                        m_tuser
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int NB_W   = ($clog2(MAX_BLOCKS + 1) > 17) ? $clog2(MAX_BLOCKS + 1) : 17;
  localparam int BLK_W  = 64 - BLOCK_SHIFT;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

  rcbc_pkg::back_state_t state, state_next;

  logic [1:0]        mem [MAX_BLOCKS];
  logic [1:0]        rd_data;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [1:0]        mem_wd;
  logic [IDX_W-1:0]  mem_ra;

  logic [IDX_W-1:0]  clear_addr;
  logic [NB_W-1:0]   nblk;
  logic [NB_W-1:0]   idx_inc;

  logic [15:0]       ld_index;
  logic [1:0]        ld_class;
  logic              ld_ok;
  logic              ld_write;
  rcbc_pkg::status_t status_q;

  logic [63:0]       cursor;
  logic [63:0]       remaining;
  logic              below_q;
  logic [63:0]       off_q;
  logic              in_reg_q;
  logic [63:0]       boundary_q;
  logic [63:0]       dist_q;
  logic              bounded_gt_q;
  logic [1:0]        cls_q;
  logic              cut;
  logic [63:0]       seg;

  logic [63:0]       eviction_total;
  logic [63:0]       byte_total;
  logic [63:0]       class_totals [4];

  logic              out_load;

  // The region never extends past the class store.
  assign nblk = (NB_W'(block_count) > NB_W'(MAX_BLOCKS)) ? NB_W'(MAX_BLOCKS)
                                                         : NB_W'(block_count);
  assign idx_inc = off_q[BLOCK_SHIFT +: NB_W] + NB_W'(1);

  assign cut = bounded_gt_q && (dist_q < remaining);
  assign seg = cut ? dist_q : remaining;

  assign ld_write = (state == rcbc_pkg::S_LD_WR) && ld_ok && (rd_data == 2'd0);
  assign clearing = state == rcbc_pkg::S_CLEAR;

  assign mem_we = clearing || ld_write;
  assign mem_wa = clearing ? clear_addr : IDX_W'(ld_index);
  assign mem_wd = clearing ? 2'd0 : ld_class;
  assign mem_ra = (state == rcbc_pkg::S_LD_RD) ? IDX_W'(ld_index)
                                               : off_q[BLOCK_SHIFT +: IDX_W];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcbc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      rcbc_pkg::S_CLEAR: begin
        if (clear_addr == LAST_IDX) begin
          state_next = rcbc_pkg::S_IDLE;
        end
      end
      rcbc_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            rcbc_pkg::CMD_LOAD: state_next = rcbc_pkg::S_LD_RD;
            rcbc_pkg::CMD_EVICT: begin
              state_next = (q_cmd.event_size == 64'd0) ? rcbc_pkg::S_EMIT
                                                       : rcbc_pkg::S_OFF;
            end
            default: state_next = rcbc_pkg::S_EMIT;
          endcase
        end
      end
      rcbc_pkg::S_LD_RD: state_next = rcbc_pkg::S_LD_WR;
      rcbc_pkg::S_LD_WR: state_next = rcbc_pkg::S_EMIT;
      rcbc_pkg::S_OFF:   state_next = rcbc_pkg::S_LOOK;
      rcbc_pkg::S_LOOK:  state_next = rcbc_pkg::S_SEG;
      rcbc_pkg::S_SEG:   state_next = rcbc_pkg::S_ACC;
      rcbc_pkg::S_ACC: begin
        // A piece that is not cut at a boundary takes all remaining bytes.
        state_next = cut ? rcbc_pkg::S_OFF : rcbc_pkg::S_EMIT;
      end
      rcbc_pkg::S_EMIT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = rcbc_pkg::S_IDLE;
        end
      end
      default: state_next = rcbc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + IDX_W'(1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      rcbc_pkg::S_IDLE: begin
        ld_index  <= q_cmd.entry_index;
        ld_class  <= q_cmd.entry_class;
        cursor    <= q_cmd.event_address;
        remaining <= q_cmd.event_size;
        status_q  <= (q_cmd.kind == rcbc_pkg::CMD_IGNORE) ? rcbc_pkg::STATUS_IGNORED
                                                           : rcbc_pkg::STATUS_OK;
      end
      rcbc_pkg::S_LD_RD: begin
        ld_ok <= (NB_W'(ld_index) < nblk) && (ld_class != 2'd0);
      end
      rcbc_pkg::S_LD_WR: begin
        status_q <= ld_write ? rcbc_pkg::STATUS_OK : rcbc_pkg::STATUS_REJECTED;
      end
      rcbc_pkg::S_OFF: begin
        below_q <= cursor < region_base;
        off_q   <= cursor - region_base;
      end
      rcbc_pkg::S_LOOK: begin
        in_reg_q   <= !below_q && (off_q[63:BLOCK_SHIFT] < BLK_W'(nblk));
        boundary_q <= below_q ? region_base
                              : region_base + 64'({idx_inc, {BLOCK_SHIFT{1'b0}}});
      end
      rcbc_pkg::S_SEG: begin
        // A boundary that wrapped past the top leaves the piece uncut.
        dist_q       <= boundary_q - cursor;
        bounded_gt_q <= (below_q || in_reg_q) && (boundary_q > cursor);
        cls_q        <= in_reg_q ? rd_data : 2'd0;
      end
      rcbc_pkg::S_ACC: begin
        cursor    <= boundary_q;
        remaining <= remaining - dist_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eviction_total  <= '0;
      byte_total      <= '0;
      class_totals[0] <= '0;
      class_totals[1] <= '0;
      class_totals[2] <= '0;
      class_totals[3] <= '0;
    end else begin
      if (q_pop && (q_cmd.kind == rcbc_pkg::CMD_EVICT)) begin
        eviction_total <= eviction_total + 64'd1;
        byte_total     <= byte_total + q_cmd.event_size;
      end
      if (state == rcbc_pkg::S_ACC) begin
        class_totals[cls_q] <= class_totals[cls_q] + seg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= status_q;
      m_tdata <= {class_totals[3], class_totals[2], class_totals[1], class_totals[0],
                  byte_total, eviction_total};
    end
  end

endmodule

### rtl/core/region_class_byte_counter.sv
// Top level of the region class byte counter: configuration registers and block wiring.
//
// Channel   Direction  Handshake                   Contents
// s_*       in         s_tvalid / s_tready         load entry or event word
// m_*       out        m_tvalid / m_tready         status and all counters
// APB       in         psel, penable, pwrite       region base at 0, block_count at 8
//
// After reset the class store is cleared one entry a cycle with s_tready low;
// configuration writes are taken during that time. In the back end a load reads
// and then writes its class store entry, an ignored event goes straight to output,
// and an eviction repeats the offset, lookup, distance and accumulate steps per piece.
// A two-word queue lets the front accept while the back works, and the output
// register holds a result until taken without blocking the next item's work.
module region_class_byte_counter #(
  parameter int MAX_BLOCKS  = rcbc_pkg::MAX_BLOCKS_DEF,
  parameter int BLOCK_SHIFT = rcbc_pkg::BLOCK_SHIFT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // entry_index[15:0], entry_class[17:16], event kind[25:18],
  // event_address[89:26], event_size[153:90], zero fill above
  input  logic [rcbc_pkg::IN_TDATA_W-1:0]   s_tdata,
  // mode[0]
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // eviction_count[63:0], evicted byte sum[127:64], class 0 bytes[191:128],
  // class 1 bytes[255:192], class 2 bytes[319:256], class 3 bytes[383:320]
  output logic [rcbc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // status[1:0]
  output logic [1:0]                        m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rcbc_pkg::PADDR_W-1:0]      paddr,
  input  logic [rcbc_pkg::PDATA_W-1:0]      pwdata,
  output logic [rcbc_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  logic [63:0]          region_base;
  logic [16:0]          block_count;
  rcbc_pkg::reg_index_t reg_sel;
  logic                 cfg_write;

  logic                 push;
  rcbc_pkg::cmd_t       push_cmd;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  rcbc_pkg::cmd_t       q_cmd;
  logic                 clearing;

  assign pready    = 1'b1;
  assign reg_sel   = rcbc_pkg::reg_index_t'(paddr[3]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= 64'd0;
      block_count <= 17'd1;
    end else if (cfg_write) begin
      unique case (reg_sel)
        rcbc_pkg::REG_REGION_BASE: region_base <= pwdata;
        rcbc_pkg::REG_BLOCK_COUNT: block_count <= pwdata[16:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      rcbc_pkg::REG_REGION_BASE: prdata = region_base;
      rcbc_pkg::REG_BLOCK_COUNT: prdata = rcbc_pkg::PDATA_W'(block_count);
      default:                   prdata = '0;
    endcase
  end

  rcbc_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  rcbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (q_cmd)
  );

  rcbc_back #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .BLOCK_SHIFT (BLOCK_SHIFT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .region_base (region_base),
    .block_count (block_count),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .clearing    (clearing),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

endmodule
